// ===== design/vnms_pkg.sv =====
// Shared constants and widths for the Voronoi normal-map sampler.
package vnms_pkg;

  localparam int MAX_GRID   = 256;
  localparam int COLOR_BITS = 16;

  localparam int G_W      = $clog2(MAX_GRID + 1);
  localparam int IDX_W    = $clog2(MAX_GRID);
  localparam int FRAC_W   = 16;
  localparam int OFS_W    = 24;
  localparam int DIFF_W   = 27;
  localparam int SQ_W     = 50;
  localparam int DIST_W   = 51;
  localparam int HASH_W   = 24;
  localparam int ANG_W    = 32;
  localparam int CS_W     = 33;
  localparam int CFG_W    = 32;
  localparam int CELL_CNT_W = 16;
  localparam int TILT_W   = 15;
  localparam int TILT_A_W = 7;
  localparam int TILT_B_W = 9;

  localparam int CELL_ONE = 2 ** 24;

  typedef enum logic [1:0] {
    REG_CELL_COUNT = 2'd0,
    REG_MAX_TILT   = 2'd1,
    REG_HASH_SEED  = 2'd2
  } reg_idx_t;

  localparam logic [1:0] CH_X    = 2'd0;
  localparam logic [1:0] CH_Y    = 2'd1;
  localparam logic [1:0] CH_TILT = 2'd2;
  localparam logic [1:0] CH_AZIM = 2'd3;

  localparam logic [31:0] HASH_KX  = 32'h9e3779b9;
  localparam logic [31:0] HASH_KY  = 32'h85ebca6b;
  localparam logic [31:0] HASH_KC  = 32'hc2b2ae35;
  localparam logic [31:0] HASH_KM1 = 32'h7feb352d;
  localparam logic [31:0] HASH_KM2 = 32'h846ca68b;

  // 89 degrees in Q7.8
  localparam logic [TILT_W-1:0] TILT_SAT = 15'd22784;
  // ceil(2^24 / 360): exact quotient for 15-bit dividends
  localparam logic [15:0] TILT_DIV_MUL = 16'd46604;
  localparam int          TILT_DIV_SH  = 24;
  localparam logic [8:0]  DEG_TURN     = 9'd360;
  // ceil(2^36 / 45): exact quotient for 30-bit dividends
  localparam logic [30:0] DIV45_MUL = 31'd1527099484;
  localparam int          DIV45_SH  = 36;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [CS_W-1:0] CORDIC_ONE_K = 33'sd652032874;
  localparam logic [29:0] ATAN_TBL [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  localparam int HASH_LAT   = 3;
  localparam int SEARCH_LAT = HASH_LAT + 7;
  localparam int THETA_LAT  = 3;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int PIPE_LAT   = 3 + SEARCH_LAT + HASH_LAT + THETA_LAT + CORDIC_LAT + 2;

endpackage

// ===== design/vnms_hash.sv =====
// Seeded integer cell hash, three register stages.
module vnms_hash import vnms_pkg::*; (
  input  logic              clk,
  input  logic [31:0]       seed,
  input  logic [IDX_W-1:0]  x,
  input  logic [IDX_W-1:0]  y,
  input  logic [1:0]        ch,
  output logic [HASH_W-1:0] h
);

  logic [31:0] mix;
  logic [31:0] mul1;
  logic [31:0] mul2;
  logic [31:0] fin;

  always_ff @(posedge clk) begin
    mix  <= seed ^ (32'(x) * HASH_KX) ^ (32'(y) * HASH_KY) ^ (32'(ch) * HASH_KC);
    mul1 <= (mix ^ (mix >> 16)) * HASH_KM1;
    mul2 <= (mul1 ^ (mul1 >> 15)) * HASH_KM2;
  end

  assign fin = mul2 ^ (mul2 >> 16);
  assign h   = fin[HASH_W-1:0];

endmodule

// ===== design/vnms_search.sv =====
// 3x3 neighbor scan: site jitter, squared distances and a registered min tree.
module vnms_search import vnms_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic [31:0]               seed,
  input  logic [2:0][IDX_W-1:0]     xs,
  input  logic [2:0][IDX_W-1:0]     ys,
  input  logic [OFS_W-1:0]          fx,
  input  logic [OFS_W-1:0]          fy,
  output logic                      out_vld,
  output logic [IDX_W-1:0]          bx,
  output logic [IDX_W-1:0]          by
);

  typedef struct packed {
    logic [DIST_W-1:0] d;
    logic [IDX_W-1:0]  x;
    logic [IDX_W-1:0]  y;
  } node_t;

  function automatic node_t pick(input node_t a, input node_t b);
    // earlier cell keeps ties
    return (b.d < a.d) ? b : a;
  endfunction

  function automatic logic signed [DIFF_W-1:0] cell_ofs(input int c);
    return DIFF_W'((1 - c) * CELL_ONE);
  endfunction

  logic [HASH_W-1:0] hx [9];
  logic [HASH_W-1:0] hy [9];

  for (genvar k = 0; k < 9; k++) begin : g_cell
    vnms_hash u_hx (.clk(clk), .seed(seed), .x(xs[k % 3]), .y(ys[k / 3]),
                    .ch(CH_X), .h(hx[k]));
    vnms_hash u_hy (.clk(clk), .seed(seed), .x(xs[k % 3]), .y(ys[k / 3]),
                    .ch(CH_Y), .h(hy[k]));
  end

  // align offsets and cells with the hash latency
  logic [HASH_LAT-1:0]          dvld;
  logic [OFS_W-1:0]             dfx [HASH_LAT];
  logic [OFS_W-1:0]             dfy [HASH_LAT];
  logic [2:0][IDX_W-1:0]        dxs [HASH_LAT];
  logic [2:0][IDX_W-1:0]        dys [HASH_LAT];

  logic                         e_vld, f_vld, g_vld;
  logic signed [DIFF_W-1:0]     ex [9];
  logic signed [DIFF_W-1:0]     ey [9];
  logic [SQ_W-1:0]              sqx [9];
  logic [SQ_W-1:0]              sqy [9];
  logic signed [2*DIFF_W-1:0]   px [9];
  logic signed [2*DIFF_W-1:0]   py [9];
  logic [2:0][IDX_W-1:0]        e_xs, e_ys, f_xs, f_ys;
  node_t                        dn [9];
  node_t                        lv1 [5];
  node_t                        lv2 [3];
  node_t                        lv3 [2];
  node_t                        best;
  logic [3:0]                   tv;

  for (genvar k = 0; k < 9; k++) begin : g_sq
    assign px[k] = ex[k] * ex[k];
    assign py[k] = ey[k] * ey[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld  <= '0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      tv    <= '0;
    end else begin
      dvld  <= {dvld[HASH_LAT-2:0], in_vld};
      e_vld <= dvld[HASH_LAT-1];
      f_vld <= e_vld;
      g_vld <= f_vld;
      tv    <= {tv[2:0], g_vld};
    end
  end

  always_ff @(posedge clk) begin
    dfx[0] <= fx;
    dfy[0] <= fy;
    dxs[0] <= xs;
    dys[0] <= ys;
    for (int i = 1; i < HASH_LAT; i++) begin
      dfx[i] <= dfx[i-1];
      dfy[i] <= dfy[i-1];
      dxs[i] <= dxs[i-1];
      dys[i] <= dys[i-1];
    end
    e_xs <= dxs[HASH_LAT-1];
    e_ys <= dys[HASH_LAT-1];
    f_xs <= e_xs;
    f_ys <= e_ys;
    for (int k = 0; k < 9; k++) begin
      ex[k] <= $signed({3'b000, dfx[HASH_LAT-1]}) + cell_ofs(k % 3)
               - $signed({3'b000, hx[k]});
      ey[k] <= $signed({3'b000, dfy[HASH_LAT-1]}) + cell_ofs(k / 3)
               - $signed({3'b000, hy[k]});
      sqx[k] <= px[k][SQ_W-1:0];
      sqy[k] <= py[k][SQ_W-1:0];
      dn[k].d <= DIST_W'(sqx[k]) + DIST_W'(sqy[k]);
      dn[k].x <= f_xs[k % 3];
      dn[k].y <= f_ys[k / 3];
    end
    for (int i = 0; i < 4; i++) begin
      lv1[i] <= pick(dn[2*i], dn[2*i+1]);
    end
    lv1[4] <= dn[8];
    lv2[0] <= pick(lv1[0], lv1[1]);
    lv2[1] <= pick(lv1[2], lv1[3]);
    lv2[2] <= lv1[4];
    lv3[0] <= pick(lv2[0], lv2[1]);
    lv3[1] <= lv2[2];
    best   <= pick(lv3[0], lv3[1]);
  end

  assign out_vld = tv[3];
  assign bx      = best.x;
  assign by      = best.y;

endmodule

// ===== design/vnms_cordic.sv =====
// Pipelined CORDIC sine and cosine of a binary angle, one rotation per stage.
module vnms_cordic import vnms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  logic [ANG_W-1:0]       ang,
  output logic                   out_vld,
  output logic signed [CS_W-1:0] cosv,
  output logic signed [CS_W-1:0] sinv
);

  logic [1:0]              q_in;
  logic [ANG_W-1:0]        ang_ofs;
  logic [ANG_W-1:0]        resid;
  logic [CORDIC_STEPS:0]   vld;
  logic signed [CS_W-1:0]  xr [CORDIC_STEPS+1];
  logic signed [CS_W-1:0]  yr [CORDIC_STEPS+1];
  logic signed [CS_W-1:0]  zr [CORDIC_STEPS+1];
  logic [1:0]              qr [CORDIC_STEPS+1];

  assign ang_ofs = ang + 32'h2000_0000;
  assign q_in    = ang_ofs[ANG_W-1 -: 2];
  assign resid   = ang - {q_in, 30'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[CORDIC_STEPS-1:0], in_vld};
      out_vld <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    xr[0] <= CORDIC_ONE_K;
    yr[0] <= '0;
    zr[0] <= CS_W'($signed(resid));
    qr[0] <= q_in;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (zr[i] >= 0) begin
        xr[i+1] <= xr[i] - (yr[i] >>> i);
        yr[i+1] <= yr[i] + (xr[i] >>> i);
        zr[i+1] <= zr[i] - $signed({3'b000, ATAN_TBL[i]});
      end else begin
        xr[i+1] <= xr[i] + (yr[i] >>> i);
        yr[i+1] <= yr[i] - (xr[i] >>> i);
        zr[i+1] <= zr[i] + $signed({3'b000, ATAN_TBL[i]});
      end
      qr[i+1] <= qr[i];
    end
    // rotate back by the quadrant
    case (qr[CORDIC_STEPS])
      2'd1: begin
        cosv <= -yr[CORDIC_STEPS];
        sinv <= xr[CORDIC_STEPS];
      end
      2'd2: begin
        cosv <= -xr[CORDIC_STEPS];
        sinv <= -yr[CORDIC_STEPS];
      end
      2'd3: begin
        cosv <= yr[CORDIC_STEPS];
        sinv <= -xr[CORDIC_STEPS];
      end
      default: begin
        cosv <= xr[CORDIC_STEPS];
        sinv <= yr[CORDIC_STEPS];
      end
    endcase
  end

endmodule

// ===== design/voronoi_normal_map_sampler_unit.sv =====
// Top level of the Voronoi normal-map sampler: config, grid mapping, tilt and color.
//
//   channel   ports                                   handshake
//   request   start, busy, u_coord, v_coord           taken when start && !busy
//   result    done, red, green, blue                  one-cycle strobe on done
//   config    cfg_write, cfg_index, cfg_data          written when cfg_write
//
// One request enters every cycle; busy stays low. The pipeline depth is set by the
// 30-stage CORDIC, the 3x3 distance tree and the hash multiplier stages. rst clears
// all valid bits, so requests in flight are dropped. Results cannot be held off; the
// pipeline never stalls.
module voronoi_normal_map_sampler_unit import vnms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     u_coord,
  input  logic signed [31:0]     v_coord,
  output logic                   done,
  output logic [COLOR_BITS-1:0]  red,
  output logic [COLOR_BITS-1:0]  green,
  output logic [COLOR_BITS-1:0]  blue,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int PU_W  = FRAC_W + G_W;
  localparam int NRM_W = 36;

  function automatic logic [G_W-1:0] grid_side(input logic [CELL_CNT_W-1:0] n);
    logic [15:0] op;
    logic [15:0] res;
    logic [15:0] one;
    logic [16:0] g;
    op  = (n == '0) ? 16'd1 : n;
    res = '0;
    one = 16'h4000;
    for (int i = 0; i < 8; i++) begin
      if (op >= res + one) begin
        op  = op - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    g = 17'(res) + 17'(op != '0);
    if (g > 17'(MAX_GRID)) g = 17'(MAX_GRID);
    return g[G_W-1:0];
  endfunction

  function automatic logic [COLOR_BITS-1:0] to_color(input logic signed [NRM_W-1:0] n);
    logic signed [NRM_W:0] v;
    logic signed [NRM_W:0] r;
    v = (NRM_W+1)'(n) + (NRM_W+1)'(2 ** 30);
    if (v < 0) v = '0;
    r = (v + (NRM_W+1)'(2 ** (30 - COLOR_BITS))) >>> (31 - COLOR_BITS);
    if (r > (NRM_W+1)'(2 ** COLOR_BITS - 1)) r = (NRM_W+1)'(2 ** COLOR_BITS - 1);
    return r[COLOR_BITS-1:0];
  endfunction

  // configuration
  logic [G_W-1:0]      grid;
  logic [TILT_W-1:0]   tilt_md;
  logic [TILT_A_W-1:0] tilt_a;
  logic [TILT_B_W-1:0] tilt_b;
  logic [31:0]         seed;
  logic [TILT_W-1:0]   md_in;
  logic [30:0]         a_prod;

  assign md_in  = (cfg_data[TILT_W-1:0] > TILT_SAT) ? TILT_SAT : cfg_data[TILT_W-1:0];
  assign a_prod = 31'(md_in) * 31'(TILT_DIV_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid    <= grid_side(16'd64);
      tilt_md <= 15'd3072;
      tilt_a  <= 7'd8;
      tilt_b  <= 9'd192;
      seed    <= 32'd1337;
    end else begin
      tilt_b <= TILT_B_W'(tilt_md - 15'(15'(tilt_a) * 15'(DEG_TURN)));
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CELL_COUNT: grid <= grid_side(cfg_data[CELL_CNT_W-1:0]);
          REG_MAX_TILT: begin
            tilt_md <= md_in;
            tilt_a  <= a_prod[TILT_DIV_SH +: TILT_A_W];
          end
          REG_HASH_SEED: seed <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign busy = 1'b0;

  // grid mapping
  logic                   v0, v1, v2;
  logic [FRAC_W-1:0]      fu, fv;
  logic [PU_W-1:0]        pu, pv;
  logic [IDX_W-1:0]       ix, iy;
  logic [OFS_W-1:0]       fx1, fy1, fx2, fy2;
  logic [2:0][IDX_W-1:0]  xs, ys;
  logic [IDX_W-1:0]       gm1;

  assign pu  = PU_W'(fu) * PU_W'(grid);
  assign pv  = PU_W'(fv) * PU_W'(grid);
  assign gm1 = IDX_W'(grid - 1'b1);

  always_ff @(posedge clk) begin
    fu  <= u_coord[FRAC_W-1:0];
    fv  <= v_coord[FRAC_W-1:0];
    ix  <= pu[FRAC_W +: IDX_W];
    iy  <= pv[FRAC_W +: IDX_W];
    fx1 <= {pu[FRAC_W-1:0], 8'b0};
    fy1 <= {pv[FRAC_W-1:0], 8'b0};
    // wrap neighbors at the grid edges
    xs[0] <= (ix == '0) ? gm1 : ix - 1'b1;
    xs[1] <= ix;
    xs[2] <= (G_W'(ix) + 1'b1 >= grid) ? '0 : ix + 1'b1;
    ys[0] <= (iy == '0) ? gm1 : iy - 1'b1;
    ys[1] <= iy;
    ys[2] <= (G_W'(iy) + 1'b1 >= grid) ? '0 : iy + 1'b1;
    fx2 <= fx1;
    fy2 <= fy1;
  end

  // nearest site
  logic             s_vld;
  logic [IDX_W-1:0] bx, by;

  vnms_search u_search (
    .clk(clk), .rst(rst), .in_vld(v2), .seed(seed),
    .xs(xs), .ys(ys), .fx(fx2), .fy(fy2),
    .out_vld(s_vld), .bx(bx), .by(by)
  );

  // tilt and azimuth of the winning cell
  logic [HASH_W-1:0]   h_tilt, h_azim;
  logic [HASH_LAT-1:0] wv;
  logic                t1v, t2v, t3v;
  logic [30:0]         ha1, ha2;
  logic [32:0]         hb1;
  logic [60:0]         qm;
  logic [ANG_W-1:0]    phi1, phi2, phi3, theta;

  vnms_hash u_hash_tilt (.clk(clk), .seed(seed), .x(bx), .y(by), .ch(CH_TILT), .h(h_tilt));
  vnms_hash u_hash_azim (.clk(clk), .seed(seed), .x(bx), .y(by), .ch(CH_AZIM), .h(h_azim));

  always_ff @(posedge clk) begin
    ha1   <= 31'(h_tilt) * 31'(tilt_a);
    hb1   <= 33'(h_tilt) * 33'(tilt_b);
    phi1  <= {h_azim, 8'b0};
    ha2   <= ha1;
    qm    <= 61'(hb1[32:3]) * 61'(DIV45_MUL);
    phi2  <= phi1;
    theta <= 32'(ha2) + 32'(qm[60:DIV45_SH]);
    phi3  <= phi2;
  end

  // sine and cosine
  logic                   c_vld, c_vld_p;
  logic signed [CS_W-1:0] ct, st, cp, sp;

  vnms_cordic u_cordic_tilt (
    .clk(clk), .rst(rst), .in_vld(t3v), .ang(theta),
    .out_vld(c_vld), .cosv(ct), .sinv(st)
  );

  vnms_cordic u_cordic_azim (
    .clk(clk), .rst(rst), .in_vld(t3v), .ang(phi3),
    .out_vld(c_vld_p), .cosv(cp), .sinv(sp)
  );

  // normal and color
  logic                     m_vld;
  logic signed [2*CS_W-1:0] nxp, nyp;
  logic signed [CS_W-1:0]   ctd;

  always_ff @(posedge clk) begin
    nxp   <= st * cp;
    nyp   <= st * sp;
    ctd   <= ct;
    red   <= to_color(nxp[30 +: NRM_W]);
    green <= to_color(nyp[30 +: NRM_W]);
    blue  <= to_color(NRM_W'(ctd));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      wv    <= '0;
      t1v   <= 1'b0;
      t2v   <= 1'b0;
      t3v   <= 1'b0;
      m_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      v0    <= start && !busy;
      v1    <= v0;
      v2    <= v1;
      wv    <= {wv[HASH_LAT-2:0], s_vld};
      t1v   <= wv[HASH_LAT-1];
      t2v   <= t1v;
      t3v   <= t2v;
      m_vld <= c_vld && c_vld_p;
      done  <= m_vld;
    end
  end

endmodule

// ===== design/vnms_checker.sv =====
// Port-level checker for the sampler, bound to the top level.
module vnms_checker import vnms_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("request produced no result after the pipeline latency");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching request");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind voronoi_normal_map_sampler_unit vnms_checker u_vnms_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
